@@ hw/rtl/bgcd_pkg.sv @@
// Shared types, constants and codes for the bounded greedy change dispenser.
`default_nettype none
package bgcd_pkg;

  localparam int NUM_SLOTS = 4;
  localparam int SLOT_MAX  = 4;
  localparam int SLOT_W    = 2;
  localparam int AMT_W     = 16;
  localparam int TALLY_W   = 32;
  localparam int CFG_IDX_W = 3;

  // register indexes: denomination values first, then piece limits
  localparam logic [CFG_IDX_W-1:0] CFG_DENOM_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_BASE = 3'd4;

  typedef logic [AMT_W-1:0]   amt_t;
  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [TALLY_W-1:0] tally_t;
  typedef amt_t [SLOT_MAX-1:0] slot_vec_t;

  localparam slot_vec_t DENOM_RST = {16'd50, 16'd10, 16'd5, 16'd1};
  localparam slot_vec_t LIMIT_RST = {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};

  typedef struct packed {
    logic start;
    amt_t dividend;
    amt_t divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/bgcd_div.sv @@
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module bgcd_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bgcd_pkg::div_req_t req,
  output bgcd_pkg::div_stat_t    stat,
  output bgcd_pkg::amt_t         quotient
);
  import bgcd_pkg::*;

  localparam int CNT_W = $clog2(AMT_W);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  amt_t             rem;
  amt_t             quo;
  amt_t             dsr;
  logic [AMT_W:0]   shifted;
  logic [AMT_W:0]   trial;
  logic             q_bit;

  assign shifted = {rem, quo[AMT_W-1]};
  assign trial   = shifted - {1'b0, dsr};
  assign q_bit   = !trial[AMT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= req.dividend;
        dsr  <= req.divisor;
      end else if (busy) begin
        rem <= q_bit ? trial[AMT_W-1:0] : shifted[AMT_W-1:0];
        quo <= {quo[AMT_W-2:0], q_bit};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(AMT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule
`default_nettype wire

@@ hw/rtl/bgcd_cfg.sv @@
// Denomination and piece limit registers with per-slot selection.
`default_nettype none
module bgcd_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [bgcd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire bgcd_pkg::amt_t                     cfg_data,
  input  wire bgcd_pkg::slot_t                    slot,
  output bgcd_pkg::amt_t                          sel_value,
  output bgcd_pkg::amt_t                          sel_limit
);
  import bgcd_pkg::*;

  slot_vec_t denom;
  slot_vec_t limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      denom <= DENOM_RST;
      limit <= LIMIT_RST;
    end else if (cfg_we) begin
      if (cfg_index < CFG_LIMIT_BASE) begin
        denom[SLOT_W'(cfg_index - CFG_DENOM_BASE)] <= cfg_data;
      end else begin
        limit[SLOT_W'(cfg_index - CFG_LIMIT_BASE)] <= cfg_data;
      end
    end
  end

  assign sel_value = denom[slot];
  assign sel_limit = limit[slot];

endmodule
`default_nettype wire

@@ hw/rtl/bounded_greedy_change_dispenser.sv @@
// Top level: slot sequencer around the shared divider, tallies and result register.
//
//   channel | signals                               | direction
//   in      | in_valid, in_ready, pay_amount        | request in
//   out     | out_valid, out_ready, slot_index,     | result out
//           | pieces_given, slot_tally,             |
//           | still_unpaid, last_slot               |
//   cfg     | cfg_we, cfg_index, cfg_data           | register write
//
// Each slot steps through load, 16 divider steps, limit clamp, multiply, subtract
// and result hand-off, and an output stall holds it in hand-off. The four slots
// run in turn from acceptance until in_ready returns, so a new request is taken
// only after the last slot's result has been handed off.
// A slot of value 0 skips the divider: load, multiply, subtract, result hand-off.
// Reset clears the tallies and the sequencer; registers return to defaults.
// in_ready is high only between requests; out_ready stalls hold the sequencer.
`default_nettype none
module bounded_greedy_change_dispenser (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire bgcd_pkg::amt_t                 pay_amount,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output bgcd_pkg::slot_t                     slot_index,
  output bgcd_pkg::amt_t                      pieces_given,
  output bgcd_pkg::tally_t                    slot_tally,
  output bgcd_pkg::amt_t                      still_unpaid,
  output logic                                last_slot,
  input  wire logic                           cfg_we,
  input  wire logic [bgcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire bgcd_pkg::amt_t                 cfg_data
);
  import bgcd_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_SUB  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]          state;
  slot_t               slot;
  amt_t                amount;
  amt_t                amount_next;
  amt_t                pieces;
  logic [2*AMT_W-1:0]  prod;
  tally_t              tally [SLOT_MAX];
  logic [TALLY_W:0]    tally_sum;
  tally_t              tally_next;

  amt_t      sel_value;
  amt_t      sel_limit;
  div_req_t  div_req;
  div_stat_t div_st;
  amt_t      quo;

  bgcd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .slot      (slot),
    .sel_value (sel_value),
    .sel_limit (sel_limit)
  );

  assign div_req.start    = (state == ST_LOAD) && (sel_value != '0);
  assign div_req.dividend = amount;
  assign div_req.divisor  = sel_value;

  bgcd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .stat     (div_st),
    .quotient (quo)
  );

  // pieces * value never exceeds the amount, so the low half is exact
  assign amount_next = amount - prod[AMT_W-1:0];
  assign tally_sum   = {1'b0, tally[slot]} + {{(TALLY_W-AMT_W+1){1'b0}}, pieces};
  assign tally_next  = tally_sum[TALLY_W] ? '1 : tally_sum[TALLY_W-1:0];

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      slot      <= '0;
      for (int i = 0; i < SLOT_MAX; i++) begin
        tally[i] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            amount <= pay_amount;
            slot   <= SLOT_W'(NUM_SLOTS - 1);
            state  <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (sel_value == '0) begin
            pieces <= '0;
            state  <= ST_MUL;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_st.done) begin
            pieces <= (quo > sel_limit) ? sel_limit : quo;
            state  <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= pieces * sel_value;
          state <= ST_SUB;
        end
        ST_SUB: begin
          amount       <= amount_next;
          tally[slot]  <= tally_next;
          slot_index   <= slot;
          pieces_given <= pieces;
          slot_tally   <= tally_next;
          still_unpaid <= amount_next;
          last_slot    <= (slot == '0);
          out_valid    <= 1'b1;
          state        <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (slot == '0) begin
              state <= ST_IDLE;
            end else begin
              slot  <= slot - 1'b1;
              state <= ST_LOAD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_out_only_in_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == ST_OUT))
    else $error("result shown outside hand-off state");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("request taken while a result is pending");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_slot) |=> in_ready)
    else $error("sequencer did not return to idle after final slot");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> (state == ST_DIV))
    else $error("divider finished outside divide state");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_slot == (slot_index == '0)))
    else $error("last flag does not match slot");

endmodule
`default_nettype wire
